### rtl/pec_pkg.sv
// shared types and constants of the polygon ear clip triangulator
`default_nettype none
package pec_pkg;

   localparam int TAG_BITS = 16;

   typedef logic [2:0] xmode_type;

   // cross product operand selection: turn(x, y, z) = (y - x) x (z - x)
   localparam xmode_type XM_OBC = 3'd0;   // origin, b, c
   localparam xmode_type XM_ABC = 3'd1;
   localparam xmode_type XM_ABP = 3'd2;
   localparam xmode_type XM_BCP = 3'd3;
   localparam xmode_type XM_CAP = 3'd4;

endpackage
`default_nettype wire

### rtl/pec_store.sv
// vertex store and live index list, synchronous memories with registered read
`default_nettype none
module pec_store #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 24,
   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                vwe,
   input  wire logic [IW-1:0]                       vwaddr,
   input  wire logic signed [COORD_BITS-1:0]        vw_u,
   input  wire logic signed [COORD_BITS-1:0]        vw_v,
   input  wire logic [pec_pkg::TAG_BITS-1:0]        vw_tag,
   input  wire logic [IW-1:0]                       vraddr,
   output logic signed [COORD_BITS-1:0]             vrd_u,
   output logic signed [COORD_BITS-1:0]             vrd_v,
   output logic [pec_pkg::TAG_BITS-1:0]             vrd_tag,
   input  wire logic                                lwe,
   input  wire logic [IW-1:0]                       lwaddr,
   input  wire logic [IW-1:0]                       lwdata,
   input  wire logic [IW-1:0]                       lraddr,
   output logic [IW-1:0]                            lrd
);
   import pec_pkg::*;

   localparam int VW = 2 * COORD_BITS + TAG_BITS;

   logic [VW-1:0] vert_mem [MAX_VERTICES];
   logic [IW-1:0] live_mem [MAX_VERTICES];
   logic [VW-1:0] vrd_ff;
   logic [IW-1:0] lrd_ff;

   always_ff @(posedge clock) begin
      if (vwe) begin
         vert_mem[vwaddr] <= {vw_u, vw_v, vw_tag};
      end
      vrd_ff <= vert_mem[vraddr];
   end

   always_ff @(posedge clock) begin
      if (lwe) begin
         live_mem[lwaddr] <= lwdata;
      end
      lrd_ff <= live_mem[lraddr];
   end

   assign vrd_u   = vrd_ff[VW-1 -: COORD_BITS];
   assign vrd_v   = vrd_ff[TAG_BITS +: COORD_BITS];
   assign vrd_tag = vrd_ff[TAG_BITS-1:0];
   assign lrd     = lrd_ff;

endmodule
`default_nettype wire

### rtl/pec_cross.sv
// two-stage exact cross product unit: differences, then products
`default_nettype none
module pec_cross #(
   parameter int COORD_BITS = 24,
   localparam int XW = 2 * COORD_BITS + 3
) (
   input  wire logic                         clock,
   input  wire pec_pkg::xmode_type           mode,
   input  wire logic signed [COORD_BITS-1:0] a_u,
   input  wire logic signed [COORD_BITS-1:0] a_v,
   input  wire logic signed [COORD_BITS-1:0] b_u,
   input  wire logic signed [COORD_BITS-1:0] b_v,
   input  wire logic signed [COORD_BITS-1:0] c_u,
   input  wire logic signed [COORD_BITS-1:0] c_v,
   input  wire logic signed [COORD_BITS-1:0] p_u,
   input  wire logic signed [COORD_BITS-1:0] p_v,
   output logic signed [XW-1:0]              res
);
   import pec_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] x_u, x_v, y_u, y_v, z_u, z_v;
   logic signed [DW-1:0] d1u_ff, d1v_ff, d2u_ff, d2v_ff;
   logic signed [DW-1:0] d1u_in, d1v_in, d2u_in, d2v_in;
   logic signed [PW-1:0] prod1_ff, prod2_ff;

   always_comb begin
      x_u = a_u; x_v = a_v; y_u = b_u; y_v = b_v; z_u = c_u; z_v = c_v;
      case (mode)
         XM_OBC: begin
            x_u = '0; x_v = '0;
         end
         XM_ABC: begin
            z_u = c_u; z_v = c_v;
         end
         XM_ABP: begin
            z_u = p_u; z_v = p_v;
         end
         XM_BCP: begin
            x_u = b_u; x_v = b_v; y_u = c_u; y_v = c_v; z_u = p_u; z_v = p_v;
         end
         XM_CAP: begin
            x_u = c_u; x_v = c_v; y_u = a_u; y_v = a_v; z_u = p_u; z_v = p_v;
         end
         default: begin
            x_u = a_u; x_v = a_v;
         end
      endcase
      d1u_in = DW'(y_u) - DW'(x_u);
      d1v_in = DW'(y_v) - DW'(x_v);
      d2u_in = DW'(z_u) - DW'(x_u);
      d2v_in = DW'(z_v) - DW'(x_v);
   end

   always_ff @(posedge clock) begin
      d1u_ff   <= d1u_in;
      d1v_ff   <= d1v_in;
      d2u_ff   <= d2u_in;
      d2v_ff   <= d2v_in;
      prod1_ff <= d1u_ff * d2v_ff;
      prod2_ff <= d1v_ff * d2u_ff;
   end

   assign res = XW'(prod1_ff) - XW'(prod2_ff);

endmodule
`default_nettype wire

### rtl/pec_ctrl.sv
// sequencer: vertex loading, orientation, convexity, ear search, fan and emission
`default_nettype none
module pec_ctrl #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 24,
   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int XW = 2 * COORD_BITS + 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_last_vertex,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pec_pkg::TAG_BITS-1:0]       rsp_corner_a,
   output logic [pec_pkg::TAG_BITS-1:0]       rsp_corner_b,
   output logic [pec_pkg::TAG_BITS-1:0]       rsp_corner_c,
   output logic                               rsp_last_triangle,
   output logic                               rsp_no_triangle,
   output logic                               rsp_overflow,
   output logic                               vwe,
   output logic [IW-1:0]                      vwaddr,
   output logic [IW-1:0]                      vraddr,
   input  wire logic signed [COORD_BITS-1:0]  vrd_u,
   input  wire logic signed [COORD_BITS-1:0]  vrd_v,
   input  wire logic [pec_pkg::TAG_BITS-1:0]  vrd_tag,
   output logic                               lwe,
   output logic [IW-1:0]                      lwaddr,
   output logic [IW-1:0]                      lwdata,
   output logic [IW-1:0]                      lraddr,
   input  wire logic [IW-1:0]                 lrd,
   output pec_pkg::xmode_type                 xmode,
   input  wire logic signed [XW-1:0]          xres,
   output logic signed [COORD_BITS-1:0]       a_u,
   output logic signed [COORD_BITS-1:0]       a_v,
   output logic signed [COORD_BITS-1:0]       b_u,
   output logic signed [COORD_BITS-1:0]       b_v,
   output logic signed [COORD_BITS-1:0]       c_u,
   output logic signed [COORD_BITS-1:0]       c_v,
   output logic signed [COORD_BITS-1:0]       p_u,
   output logic signed [COORD_BITS-1:0]       p_v
);
   import pec_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = 2 * COORD_BITS + CW + 2;

   localparam logic [4:0] ST_LOAD    = 5'd0;
   localparam logic [4:0] ST_START   = 5'd1;
   localparam logic [4:0] ST_SHORT   = 5'd2;
   localparam logic [4:0] ST_AR_LOOP = 5'd3;
   localparam logic [4:0] ST_AR_X    = 5'd4;
   localparam logic [4:0] ST_AR_ACC  = 5'd5;
   localparam logic [4:0] ST_AR_END  = 5'd6;
   localparam logic [4:0] ST_CV_A    = 5'd7;
   localparam logic [4:0] ST_CV_B    = 5'd8;
   localparam logic [4:0] ST_CV_C    = 5'd9;
   localparam logic [4:0] ST_CV_X    = 5'd10;
   localparam logic [4:0] ST_CV_T    = 5'd11;
   localparam logic [4:0] ST_EC_INIT = 5'd12;
   localparam logic [4:0] ST_EC_OUT  = 5'd13;
   localparam logic [4:0] ST_EC_A    = 5'd14;
   localparam logic [4:0] ST_EC_B    = 5'd15;
   localparam logic [4:0] ST_EC_C    = 5'd16;
   localparam logic [4:0] ST_EC_X    = 5'd17;
   localparam logic [4:0] ST_EC_T    = 5'd18;
   localparam logic [4:0] ST_EC_NEXT = 5'd19;
   localparam logic [4:0] ST_EC_O    = 5'd20;
   localparam logic [4:0] ST_EC_P0   = 5'd21;
   localparam logic [4:0] ST_EC_P1   = 5'd22;
   localparam logic [4:0] ST_EC_P2   = 5'd23;
   localparam logic [4:0] ST_EC_P3   = 5'd24;
   localparam logic [4:0] ST_EC_EMIT = 5'd25;
   localparam logic [4:0] ST_MV_R    = 5'd26;
   localparam logic [4:0] ST_MV_W    = 5'd27;
   localparam logic [4:0] ST_FN_A    = 5'd28;
   localparam logic [4:0] ST_FN_B    = 5'd29;
   localparam logic [4:0] ST_FN_C    = 5'd30;
   localparam logic [4:0] ST_FN_E    = 5'd31;

   // fetch and cross sub-sequences use a separate code space in their own two-bit register
   localparam logic [1:0] SUB_NONE = 2'd0;
   localparam logic [1:0] SUB_FD   = 2'd1;
   localparam logic [1:0] SUB_FL   = 2'd2;
   localparam logic [1:0] SUB_X    = 2'd3;

   localparam logic [1:0] SL_A = 2'd0;
   localparam logic [1:0] SL_B = 2'd1;
   localparam logic [1:0] SL_C = 2'd2;
   localparam logic [1:0] SL_P = 2'd3;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  sub_ff, sub_in;
   logic        phase_ff, phase_in;
   logic [1:0]  fslot_ff, fslot_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] o_ff, o_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] live_ff, live_in;
   logic        ovf_ff, ovf_in;
   logic        rev_ff, rev_in;
   logic        use_live_ff, use_live_in;
   logic        neg_ff, neg_in, pos_ff, pos_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   xmode_type   xmode_ff, xmode_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [TAG_BITS-1:0] ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic        last_ff, last_in, none_ff, none_in, rovf_ff, rovf_in;

   logic signed [COORD_BITS-1:0] au_ff, av_ff, bu_ff, bv_ff, cu_ff, cv_ff, pu_ff, pv_ff;
   logic signed [COORD_BITS-1:0] au_in, av_in, bu_in, bv_in, cu_in, cv_in, pu_in, pv_in;
   logic [TAG_BITS-1:0] at_ff, bt_ff, ct_ff, at_in, bt_in, ct_in;

   logic          call_en, call_live, xcall_en;
   logic [CW-1:0] call_idx;
   logic [1:0]    call_slot;
   logic [4:0]    call_ret;
   xmode_type     call_mode;
   logic [CW-1:0] map_src, map_out, cnt_next;
   logic [CW:0]   i_p2;
   logic [CW-1:0] ip, inx;
   logic          room, out_free, xneg, xpos, fneg, fpos;

   assign xneg = xres[XW-1];
   assign xpos = !xres[XW-1] && (xres != '0);
   assign room = count_ff < CW'(MAX_VERTICES);
   assign cnt_next = room ? count_ff + CW'(1) : count_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ip  = (i_ff == '0) ? live_ff - CW'(1) : i_ff - CW'(1);
   assign inx = (i_ff + CW'(1) == live_ff) ? '0 : i_ff + CW'(1);
   assign i_p2 = {1'b0, i_ff} + (CW+1)'(2);
   assign map_out = rev_ff ? (n_ff - CW'(1) - map_src) : map_src;
   assign fneg = neg_ff || xneg;
   assign fpos = pos_ff || xpos;

   always_comb begin
      state_in = state_ff; sub_in = sub_ff; phase_in = phase_ff;
      fslot_in = fslot_ff; fidx_in = fidx_ff;
      count_in = count_ff; n_in = n_ff; i_in = i_ff; o_in = o_ff; k_in = k_ff;
      live_in = live_ff; ovf_in = ovf_ff; rev_in = rev_ff; use_live_in = use_live_ff;
      neg_in = neg_ff; pos_in = pos_ff; acc_in = acc_ff; xmode_in = xmode_ff;
      rsp_valid_in = rsp_valid_ff;
      ca_in = ca_ff; cb_in = cb_ff; cc_in = cc_ff;
      last_in = last_ff; none_in = none_ff; rovf_in = rovf_ff;
      au_in = au_ff; av_in = av_ff; at_in = at_ff;
      bu_in = bu_ff; bv_in = bv_ff; bt_in = bt_ff;
      cu_in = cu_ff; cv_in = cv_ff; ct_in = ct_ff;
      pu_in = pu_ff; pv_in = pv_ff;
      call_en = 1'b0; call_live = 1'b0; xcall_en = 1'b0;
      call_idx = '0; call_slot = SL_A; call_ret = state_ff; call_mode = XM_ABC;
      map_src = '0;
      vwe = 1'b0; vwaddr = count_ff[IW-1:0]; vraddr = '0;
      lwe = 1'b0; lwaddr = '0; lwdata = '0; lraddr = '0;
      req_stall = (state_ff != ST_LOAD) || (sub_ff != SUB_NONE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (sub_ff != SUB_NONE) begin
         // shared fetch / cross sub-sequence, returns to state_ff
         case (sub_ff)
            SUB_FD: begin
               if (!phase_ff) begin
                  map_src = {{(CW-IW){1'b0}}, fidx_ff};
                  vraddr = map_out[IW-1:0];
                  phase_in = 1'b1;
               end else begin
                  sub_in = SUB_NONE;
                  phase_in = 1'b0;
               end
            end
            SUB_FL: begin
               if (!phase_ff) begin
                  lraddr = fidx_ff;
                  phase_in = 1'b1;
               end else begin
                  map_src = {{(CW-IW){1'b0}}, lrd};
                  vraddr = map_out[IW-1:0];
                  sub_in = SUB_FD;
               end
            end
            SUB_X: begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  sub_in = SUB_NONE;
                  phase_in = 1'b0;
               end
            end
            default: begin
               sub_in = SUB_NONE;
            end
         endcase
         // capture of fetched vertex on the last fetch cycle
         if (sub_ff == SUB_FD && phase_ff) begin
            case (fslot_ff)
               SL_A: begin
                  au_in = vrd_u; av_in = vrd_v; at_in = vrd_tag;
               end
               SL_B: begin
                  bu_in = vrd_u; bv_in = vrd_v; bt_in = vrd_tag;
               end
               SL_C: begin
                  cu_in = vrd_u; cv_in = vrd_v; ct_in = vrd_tag;
               end
               default: begin
                  pu_in = vrd_u; pv_in = vrd_v;
               end
            endcase
         end
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_valid) begin
                  vwe = room;
                  count_in = cnt_next;
                  if (!room) begin
                     ovf_in = 1'b1;
                  end
                  if (req_last_vertex) begin
                     n_in = cnt_next;
                     state_in = ST_START;
                  end
               end
            end
            ST_START: begin
               rev_in = 1'b0;
               acc_in = '0;
               i_in = '0;
               if (n_ff < CW'(3)) begin
                  state_in = ST_SHORT;
               end else begin
                  call_en = 1'b1; call_idx = '0; call_slot = SL_C; call_ret = ST_AR_LOOP;
               end
            end
            ST_SHORT: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  ca_in = '0; cb_in = '0; cc_in = '0;
                  last_in = 1'b1; none_in = 1'b1; rovf_in = ovf_ff;
                  count_in = '0; ovf_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end
            ST_AR_LOOP: begin
               bu_in = cu_ff; bv_in = cv_ff; bt_in = ct_ff;
               call_en = 1'b1; call_slot = SL_C; call_ret = ST_AR_X;
               call_idx = (i_ff + CW'(1) == n_ff) ? '0 : i_ff + CW'(1);
            end
            ST_AR_X: begin
               xcall_en = 1'b1; call_mode = XM_OBC; call_ret = ST_AR_ACC;
            end
            ST_AR_ACC: begin
               acc_in = acc_ff + AW'(xres);
               if (i_ff + CW'(1) == n_ff) begin
                  state_in = ST_AR_END;
               end else begin
                  i_in = i_ff + CW'(1);
                  state_in = ST_AR_LOOP;
               end
            end
            ST_AR_END: begin
               rev_in = acc_ff[AW-1];
               neg_in = 1'b0; pos_in = 1'b0;
               i_in = '0;
               if (n_ff == CW'(3)) begin
                  live_in = n_ff; use_live_in = 1'b0; i_in = CW'(1);
                  state_in = ST_FN_A;
               end else begin
                  state_in = ST_CV_A;
               end
            end
            ST_CV_A: begin
               call_en = 1'b1; call_idx = i_ff; call_slot = SL_A; call_ret = ST_CV_B;
            end
            ST_CV_B: begin
               call_en = 1'b1; call_slot = SL_B; call_ret = ST_CV_C;
               call_idx = (i_ff + CW'(1) == n_ff) ? '0 : i_ff + CW'(1);
            end
            ST_CV_C: begin
               call_en = 1'b1; call_slot = SL_C; call_ret = ST_CV_X;
               call_idx = (i_p2 >= {1'b0, n_ff}) ? CW'(i_p2 - {1'b0, n_ff}) : CW'(i_p2);
            end
            ST_CV_X: begin
               xcall_en = 1'b1; call_mode = XM_ABC; call_ret = ST_CV_T;
            end
            ST_CV_T: begin
               neg_in = fneg; pos_in = fpos;
               if (i_ff + CW'(1) == n_ff) begin
                  if (!(fneg && fpos)) begin
                     live_in = n_ff; use_live_in = 1'b0; i_in = CW'(1);
                     state_in = ST_FN_A;
                  end else begin
                     i_in = '0;
                     state_in = ST_EC_INIT;
                  end
               end else begin
                  i_in = i_ff + CW'(1);
                  state_in = ST_CV_A;
               end
            end
            ST_EC_INIT: begin
               lwe = 1'b1; lwaddr = i_ff[IW-1:0]; lwdata = i_ff[IW-1:0];
               if (i_ff + CW'(1) == n_ff) begin
                  live_in = n_ff; use_live_in = 1'b1;
                  state_in = ST_EC_OUT;
               end else begin
                  i_in = i_ff + CW'(1);
               end
            end
            ST_EC_OUT: begin
               if (live_ff <= CW'(3)) begin
                  i_in = CW'(1);
                  state_in = ST_FN_A;
               end else begin
                  i_in = '0;
                  state_in = ST_EC_A;
               end
            end
            ST_EC_A: begin
               call_en = 1'b1; call_live = 1'b1; call_idx = ip;
               call_slot = SL_A; call_ret = ST_EC_B;
            end
            ST_EC_B: begin
               call_en = 1'b1; call_live = 1'b1; call_idx = i_ff;
               call_slot = SL_B; call_ret = ST_EC_C;
            end
            ST_EC_C: begin
               call_en = 1'b1; call_live = 1'b1; call_idx = inx;
               call_slot = SL_C; call_ret = ST_EC_X;
            end
            ST_EC_X: begin
               xcall_en = 1'b1; call_mode = XM_ABC; call_ret = ST_EC_T;
            end
            ST_EC_T: begin
               if (!xpos) begin
                  state_in = ST_EC_NEXT;
               end else begin
                  o_in = '0;
                  state_in = ST_EC_O;
               end
            end
            ST_EC_NEXT: begin
               if (i_ff + CW'(1) == live_ff) begin
                  i_in = CW'(1);
                  state_in = ST_FN_A;
               end else begin
                  i_in = i_ff + CW'(1);
                  state_in = ST_EC_A;
               end
            end
            ST_EC_O: begin
               if (o_ff == live_ff) begin
                  state_in = ST_EC_EMIT;
               end else if (o_ff == i_ff || o_ff == ip || o_ff == inx) begin
                  o_in = o_ff + CW'(1);
               end else begin
                  call_en = 1'b1; call_live = 1'b1; call_idx = o_ff;
                  call_slot = SL_P; call_ret = ST_EC_P0;
               end
            end
            ST_EC_P0: begin
               neg_in = 1'b0; pos_in = 1'b0;
               xcall_en = 1'b1; call_mode = XM_ABP; call_ret = ST_EC_P1;
            end
            ST_EC_P1: begin
               neg_in = fneg; pos_in = fpos;
               xcall_en = 1'b1; call_mode = XM_BCP; call_ret = ST_EC_P2;
            end
            ST_EC_P2: begin
               neg_in = fneg; pos_in = fpos;
               xcall_en = 1'b1; call_mode = XM_CAP; call_ret = ST_EC_P3;
            end
            ST_EC_P3: begin
               if (!(fneg && fpos)) begin
                  state_in = ST_EC_NEXT;
               end else begin
                  o_in = o_ff + CW'(1);
                  state_in = ST_EC_O;
               end
            end
            ST_EC_EMIT: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  ca_in = at_ff; cb_in = bt_ff; cc_in = ct_ff;
                  last_in = 1'b0; none_in = 1'b0; rovf_in = ovf_ff;
                  k_in = i_ff;
                  state_in = ST_MV_R;
               end
            end
            ST_MV_R: begin
               if (k_ff + CW'(1) == live_ff) begin
                  live_in = live_ff - CW'(1);
                  state_in = ST_EC_OUT;
               end else begin
                  lraddr = IW'(k_ff + CW'(1));
                  state_in = ST_MV_W;
               end
            end
            ST_MV_W: begin
               lwe = 1'b1; lwaddr = k_ff[IW-1:0]; lwdata = lrd;
               k_in = k_ff + CW'(1);
               state_in = ST_MV_R;
            end
            ST_FN_A: begin
               call_en = 1'b1; call_live = use_live_ff; call_idx = '0;
               call_slot = SL_A; call_ret = ST_FN_B;
            end
            ST_FN_B: begin
               call_en = 1'b1; call_live = use_live_ff; call_idx = i_ff;
               call_slot = SL_B; call_ret = ST_FN_C;
            end
            ST_FN_C: begin
               call_en = 1'b1; call_live = use_live_ff; call_idx = i_ff + CW'(1);
               call_slot = SL_C; call_ret = ST_FN_E;
            end
            ST_FN_E: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  ca_in = at_ff; cb_in = bt_ff; cc_in = ct_ff;
                  none_in = 1'b0; rovf_in = ovf_ff;
                  last_in = (i_p2 == {1'b0, live_ff});
                  if (i_p2 == {1'b0, live_ff}) begin
                     count_in = '0; ovf_in = 1'b0;
                     state_in = ST_LOAD;
                  end else begin
                     i_in = i_ff + CW'(1);
                     state_in = ST_FN_A;
                  end
               end
            end
            default: begin
               state_in = ST_LOAD;
            end
         endcase

         if (call_en) begin
            fidx_in = call_idx[IW-1:0];
            fslot_in = call_slot;
            state_in = call_ret;
            sub_in = call_live ? SUB_FL : SUB_FD;
            phase_in = 1'b0;
         end
         if (xcall_en) begin
            xmode_in = call_mode;
            state_in = call_ret;
            sub_in = SUB_X;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         sub_ff       <= SUB_NONE;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fslot_ff <= fslot_in; fidx_ff <= fidx_in;
      n_ff <= n_in; i_ff <= i_in; o_ff <= o_in; k_ff <= k_in; live_ff <= live_in;
      rev_ff <= rev_in; use_live_ff <= use_live_in;
      neg_ff <= neg_in; pos_ff <= pos_in; acc_ff <= acc_in; xmode_ff <= xmode_in;
      ca_ff <= ca_in; cb_ff <= cb_in; cc_ff <= cc_in;
      last_ff <= last_in; none_ff <= none_in; rovf_ff <= rovf_in;
      au_ff <= au_in; av_ff <= av_in; at_ff <= at_in;
      bu_ff <= bu_in; bv_ff <= bv_in; bt_ff <= bt_in;
      cu_ff <= cu_in; cv_ff <= cv_in; ct_ff <= ct_in;
      pu_ff <= pu_in; pv_ff <= pv_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_corner_a      = ca_ff;
   assign rsp_corner_b      = cb_ff;
   assign rsp_corner_c      = cc_ff;
   assign rsp_last_triangle = last_ff;
   assign rsp_no_triangle   = none_ff;
   assign rsp_overflow      = rovf_ff;
   assign xmode = xmode_ff;
   assign a_u = au_ff; assign a_v = av_ff;
   assign b_u = bu_ff; assign b_v = bv_ff;
   assign c_u = cu_ff; assign c_v = cv_ff;
   assign p_u = pu_ff; assign p_v = pv_ff;

endmodule
`default_nettype wire

### rtl/polygon_ear_clip_triangulator.sv
// top level of the polygon ear clip triangulator
`default_nettype none
// Loads one polygon ring, one vertex per cycle, into an on-chip vertex memory
// (MAX_VERTICES entries); vertices past capacity are dropped and every result
// of that ring carries overflow. The beat with last_vertex starts the
// triangulation and req_stall stays high until the last triangle of the ring
// has been handed to the output register. Every memory access takes a
// registered read, and every geometric test goes through one two-stage cross
// product unit, so the walk is slow: in the worst case the ear search grows
// as n cubed. A ring with negative signed area is walked in reverse through
// address mapping, not by moving entries. All tests are exact integer arithmetic.
module polygon_ear_clip_triangulator #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_u,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_v,
   input  wire logic [pec_pkg::TAG_BITS-1:0]  req_source_tag,
   input  wire logic                          req_last_vertex,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pec_pkg::TAG_BITS-1:0]       rsp_corner_a,
   output logic [pec_pkg::TAG_BITS-1:0]       rsp_corner_b,
   output logic [pec_pkg::TAG_BITS-1:0]       rsp_corner_c,
   output logic                               rsp_last_triangle,
   output logic                               rsp_no_triangle,
   output logic                               rsp_overflow
);
   import pec_pkg::*;

   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int XW = 2 * COORD_BITS + 3;

   // memory side
   logic                          vwe, lwe;
   logic [IW-1:0]                 vwaddr, vraddr, lwaddr, lwdata, lraddr, lrd;
   logic signed [COORD_BITS-1:0]  vrd_u, vrd_v;
   logic [TAG_BITS-1:0]           vrd_tag;

   // cross product operands and result
   xmode_type                     xmode;
   logic signed [XW-1:0]          xres;
   logic signed [COORD_BITS-1:0]  a_u, a_v, b_u, b_v, c_u, c_v, p_u, p_v;

   pec_store #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) u_store (
      .clock  (clock),
      .vwe    (vwe),
      .vwaddr (vwaddr),
      .vw_u   (req_coord_u),
      .vw_v   (req_coord_v),
      .vw_tag (req_source_tag),
      .vraddr (vraddr),
      .vrd_u  (vrd_u),
      .vrd_v  (vrd_v),
      .vrd_tag(vrd_tag),
      .lwe    (lwe),
      .lwaddr (lwaddr),
      .lwdata (lwdata),
      .lraddr (lraddr),
      .lrd    (lrd)
   );

   pec_cross #(
      .COORD_BITS(COORD_BITS)
   ) u_cross (
      .clock(clock),
      .mode (xmode),
      .a_u(a_u), .a_v(a_v), .b_u(b_u), .b_v(b_v),
      .c_u(c_u), .c_v(c_v), .p_u(p_u), .p_v(p_v),
      .res  (xres)
   );

   pec_ctrl #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_corner_a     (rsp_corner_a),
      .rsp_corner_b     (rsp_corner_b),
      .rsp_corner_c     (rsp_corner_c),
      .rsp_last_triangle(rsp_last_triangle),
      .rsp_no_triangle  (rsp_no_triangle),
      .rsp_overflow     (rsp_overflow),
      .vwe              (vwe),
      .vwaddr           (vwaddr),
      .vraddr           (vraddr),
      .vrd_u            (vrd_u),
      .vrd_v            (vrd_v),
      .vrd_tag          (vrd_tag),
      .lwe              (lwe),
      .lwaddr           (lwaddr),
      .lwdata           (lwdata),
      .lraddr           (lraddr),
      .lrd              (lrd),
      .xmode            (xmode),
      .xres             (xres),
      .a_u(a_u), .a_v(a_v), .b_u(b_u), .b_v(b_v),
      .c_u(c_u), .c_v(c_v), .p_u(p_u), .p_v(p_v)
   );

endmodule
`default_nettype wire

### rtl/pec_checker.sv
// port-level checks of the triangulator result channel and their binding
`default_nettype none
module pec_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [pec_pkg::TAG_BITS-1:0]  rsp_corner_a,
   input wire logic [pec_pkg::TAG_BITS-1:0]  rsp_corner_b,
   input wire logic [pec_pkg::TAG_BITS-1:0]  rsp_corner_c,
   input wire logic                          rsp_last_triangle,
   input wire logic                          rsp_no_triangle,
   input wire logic                          rsp_overflow
);
   import pec_pkg::*;

   // a short ring gives exactly one result, so it closes the ring
   a_short_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_triangle |-> rsp_last_triangle)
      else $error("short ring result without last_triangle");

   // a short ring result carries zero corners
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_triangle |->
         rsp_corner_a == '0 && rsp_corner_b == '0 && rsp_corner_c == '0)
      else $error("short ring result with nonzero corners");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_corner_a) &&
         $stable(rsp_corner_b) && $stable(rsp_corner_c) &&
         $stable(rsp_last_triangle) && $stable(rsp_overflow))
      else $error("stalled result changed");

endmodule

bind polygon_ear_clip_triangulator pec_checker u_pec_checker (.*);
`default_nettype wire

### tb/polygon_ear_clip_triangulator_tb.sv
// testbench of the polygon ear clip triangulator: predicted triangles checked beat by beat
`default_nettype none

// one triangle beat as the block should emit it
typedef struct packed {
   logic [15:0] corner_a;
   logic [15:0] corner_b;
   logic [15:0] corner_c;
   logic        last_triangle;
   logic        no_triangle;
   logic        overflow;
} triangle_beat_type;

class triangle_board;
   localparam int CAPACITY = 64;

   longint            ring_u [CAPACITY];
   longint            ring_v [CAPACITY];
   logic [15:0]       ring_tag [CAPACITY];
   int                held;
   bit                dropped;
   triangle_beat_type pending_q [$];
   int                errors;

   function new();
      held = 0;
      dropped = 0;
      errors = 0;
   endfunction

   function longint turn(int a, int b, int c);
      return (ring_u[b] - ring_u[a]) * (ring_v[c] - ring_v[a])
           - (ring_v[b] - ring_v[a]) * (ring_u[c] - ring_u[a]);
   endfunction

   function bit covers(int p, int a, int b, int c);
      longint s0, s1, s2;
      s0 = turn(a, b, p);
      s1 = turn(b, c, p);
      s2 = turn(c, a, p);
      return !((s0 < 0 || s1 < 0 || s2 < 0) && (s0 > 0 || s1 > 0 || s2 > 0));
   endfunction

   function void add_triangle(ref triangle_beat_type ring_q[$], input int a, int b, int c);
      triangle_beat_type t;
      t.corner_a = ring_tag[a];
      t.corner_b = ring_tag[b];
      t.corner_c = ring_tag[c];
      t.last_triangle = 0;
      t.no_triangle = 0;
      t.overflow = dropped;
      ring_q.insert(ring_q.size(), t);
   endfunction

   // works out the triangles of the held ring
   function void split_ring();
      triangle_beat_type ring_q [$];
      triangle_beat_type t;
      longint area, tu, tv, tn;
      logic [15:0] tt;
      int alive [CAPACITY];
      int n, live, ip, inx, a, b, c, k;
      bit neg, pos, clipped, hit;
      n = held;
      if (n < 3) begin
         t = '0;
         t.last_triangle = 1;
         t.no_triangle = 1;
         t.overflow = dropped;
         pending_q.insert(pending_q.size(), t);
         return;
      end
      area = 0;
      for (int i = 0; i < n; i++) begin
         k = (i + 1 == n) ? 0 : i + 1;
         area += ring_u[i] * ring_v[k] - ring_u[k] * ring_v[i];
      end
      // clockwise rings are walked the other way round
      if (area < 0) begin
         for (int i = 0; i < n / 2; i++) begin
            k = n - 1 - i;
            tu = ring_u[i]; tv = ring_v[i]; tt = ring_tag[i];
            ring_u[i] = ring_u[k]; ring_v[i] = ring_v[k]; ring_tag[i] = ring_tag[k];
            ring_u[k] = tu; ring_v[k] = tv; ring_tag[k] = tt;
         end
      end
      neg = 0;
      pos = 0;
      if (n >= 4) begin
         for (int i = 0; i < n; i++) begin
            tn = turn(i, (i + 1) % n, (i + 2) % n);
            if (tn < 0) neg = 1;
            if (tn > 0) pos = 1;
         end
      end
      if (!(neg && pos)) begin
         for (int i = 1; i + 1 < n; i++) add_triangle(ring_q, 0, i, i + 1);
      end else begin
         for (int i = 0; i < n; i++) alive[i] = i;
         live = n;
         while (live > 3) begin
            clipped = 0;
            for (int i = 0; i < live && !clipped; i++) begin
               ip = (i + live - 1) % live;
               inx = (i + 1) % live;
               a = alive[ip];
               b = alive[i];
               c = alive[inx];
               if (turn(a, b, c) <= 0) continue;
               hit = 0;
               for (int o = 0; o < live && !hit; o++) begin
                  if (o == i || o == ip || o == inx) continue;
                  hit = covers(alive[o], a, b, c);
               end
               if (hit) continue;
               add_triangle(ring_q, a, b, c);
               for (int j = i; j + 1 < live; j++) alive[j] = alive[j + 1];
               live--;
               clipped = 1;
            end
            if (!clipped) break;
         end
         // no ear left, or three vertices remain: fan what survives
         for (int i = 1; i + 1 < live; i++) add_triangle(ring_q, alive[0], alive[i], alive[i + 1]);
      end
      if (ring_q.size() > 0) ring_q[ring_q.size() - 1].last_triangle = 1;
      foreach (ring_q[i]) pending_q.insert(pending_q.size(), ring_q[i]);
   endfunction

   // notes one accepted vertex beat
   function void note_vertex(logic signed [23:0] u, logic signed [23:0] v,
                             logic [15:0] tag, logic last);
      if (held < CAPACITY) begin
         ring_u[held] = longint'(u);
         ring_v[held] = longint'(v);
         ring_tag[held] = tag;
         held++;
      end else begin
         dropped = 1;
      end
      if (last) begin
         split_ring();
         held = 0;
         dropped = 0;
      end
   endfunction

   // checks one accepted triangle beat
   function void check_triangle(triangle_beat_type got);
      triangle_beat_type exp_t;
      if (pending_q.size() == 0) begin
         $error("unexpected triangle beat %h", got);
         errors++;
         return;
      end
      exp_t = pending_q.pop_front();
      if (got.corner_a !== exp_t.corner_a) begin
         $error("corner_a: expected %h, got %h", exp_t.corner_a, got.corner_a); errors++;
      end
      if (got.corner_b !== exp_t.corner_b) begin
         $error("corner_b: expected %h, got %h", exp_t.corner_b, got.corner_b); errors++;
      end
      if (got.corner_c !== exp_t.corner_c) begin
         $error("corner_c: expected %h, got %h", exp_t.corner_c, got.corner_c); errors++;
      end
      if (got.last_triangle !== exp_t.last_triangle) begin
         $error("last_triangle: expected %b, got %b", exp_t.last_triangle, got.last_triangle);
         errors++;
      end
      if (got.no_triangle !== exp_t.no_triangle) begin
         $error("no_triangle: expected %b, got %b", exp_t.no_triangle, got.no_triangle);
         errors++;
      end
      if (got.overflow !== exp_t.overflow) begin
         $error("overflow: expected %b, got %b", exp_t.overflow, got.overflow); errors++;
      end
   endfunction
endclass

module polygon_ear_clip_triangulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [23:0] req_coord_u;
   logic signed [23:0] req_coord_v;
   logic [15:0]        req_source_tag;
   logic               req_last_vertex;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_corner_a;
   logic [15:0]        rsp_corner_b;
   logic [15:0]        rsp_corner_c;
   logic               rsp_last_triangle;
   logic               rsp_no_triangle;
   logic               rsp_overflow;

   triangle_board board = new();

   // calm turns off random idling on both sides; hold_off asks the receiver for a long stall
   bit calm;
   bit hold_off;
   int sent;

   // vertices of the ring being built
   logic signed [23:0] build_u [$];
   logic signed [23:0] build_v [$];

   polygon_ear_clip_triangulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_u(req_coord_u), .req_coord_v(req_coord_v),
      .req_source_tag(req_source_tag), .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_corner_a(rsp_corner_a), .rsp_corner_b(rsp_corner_b),
      .rsp_corner_c(rsp_corner_c), .rsp_last_triangle(rsp_last_triangle),
      .rsp_no_triangle(rsp_no_triangle), .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // generous ceiling on the whole run
   initial begin
      #40ms;
      $display("FAILED: results differ");
      $finish;
   end

   // one vertex beat, held until the block takes it
   task send_vertex(logic signed [23:0] u, logic signed [23:0] v, logic [15:0] tag, logic last);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_coord_u <= u;
      req_coord_v <= v;
      req_source_tag <= tag;
      req_last_vertex <= last;
      do @(posedge clock); while (req_stall);
      board.note_vertex(u, v, tag, last);
      sent++;
   endtask

   // sends the built ring with random tags, last_vertex on the final beat
   task send_ring();
      for (int i = 0; i < build_u.size(); i++)
         send_vertex(build_u[i], build_v[i], 16'($urandom), i == build_u.size() - 1);
      build_u.delete();
      build_v.delete();
   endtask

   task add_point(int u, int v);
      build_u.insert(build_u.size(), 24'(u));
      build_v.insert(build_v.size(), 24'(v));
   endtask

   // convex chain on a parabola, optionally clockwise
   task convex_ring(int n, bit clockwise);
      for (int i = 0; i < n; i++) begin
         int k;
         k = clockwise ? n - 1 - i : i;
         add_point(24'(k * 1000 - 30000), 24'(k * k * 100 - 200000));
      end
   endtask

   // drops valid and waits until every expected beat has been checked
   task wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
   endtask

   // receiver: checks accepted beats and stalls at random
   initial begin
      int hold_count;
      triangle_beat_type got;
      hold_count = 0;
      rsp_stall = 1;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.corner_a = rsp_corner_a;
            got.corner_b = rsp_corner_b;
            got.corner_c = rsp_corner_c;
            got.last_triangle = rsp_last_triangle;
            got.no_triangle = rsp_no_triangle;
            got.overflow = rsp_overflow;
            board.check_triangle(got);
         end
         if (hold_off && hold_count == 0) hold_count = 400;
         if (hold_count > 0) begin
            // long hold-off so the block backs up onto its input
            hold_count--;
            if (hold_count == 0) hold_off = 0;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 12);
         end
      end
   end

   initial begin
      calm = 0;
      hold_off = 0;
      sent = 0;
      reset = 1;
      req_valid = 0;
      req_coord_u = 0;
      req_coord_v = 0;
      req_source_tag = 0;
      req_last_vertex = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // short rings: one vertex, then two
      send_vertex(24'sd0, 24'sd0, 16'h0000, 1'b1);
      send_vertex(24'sd5, 24'sd5, 16'hffff, 1'b0);
      send_vertex(-24'sd5, 24'sd5, 16'h1234, 1'b1);
      // triangle at the coordinate extremes, counterclockwise then clockwise
      add_point(24'h800000, 24'h800000);
      add_point(24'h7fffff, 24'h800000);
      add_point(24'h7fffff, 24'h7fffff);
      send_ring();
      add_point(24'h800000, 24'h800000);
      add_point(24'h7fffff, 24'h7fffff);
      add_point(24'h7fffff, 24'h800000);
      send_ring();
      // collinear ring: every corner degenerate
      add_point(0, 0); add_point(1, 1); add_point(2, 2); add_point(3, 3);
      send_ring();
      // concave arrowhead
      add_point(0, 0); add_point(10, 0); add_point(4, 3); add_point(10, 10);
      send_ring();
      // square with a vertex sitting on a candidate ear edge
      add_point(0, 0); add_point(4, 0); add_point(4, 4); add_point(2, 2); add_point(0, 4);
      send_ring();

      // sender stops until the ring is fully out
      wait_drained();

      // 40-vertex convex ring while the receiver holds off
      hold_off = 1;
      convex_ring(40, 0);
      send_ring();
      convex_ring(5, 1);
      send_ring();
      wait_drained();

      // over capacity: the last beat itself is dropped
      convex_ring(66, $urandom_range(1));
      send_ring();
      wait_drained();

      // random rings, with one long stretch without idling
      while (sent < 350) begin
         int n, kind;
         calm = (sent > 200 && sent < 280);
         kind = $urandom_range(9);
         n = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         if (kind == 1) begin
            convex_ring($urandom_range(4, 20), $urandom_range(1));
         end else if (kind < 5) begin
            // small grid: collinear runs, shared points and edges
            for (int i = 0; i < n; i++)
               add_point(24'($signed($urandom_range(8)) - 4), 24'($signed($urandom_range(8)) - 4));
         end else begin
            for (int i = 0; i < n; i++) add_point(24'($urandom), 24'($urandom));
         end
         send_ring();
      end
      calm = 0;

      wait_drained();
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

`default_nettype wire

### sim.f
rtl/pec_pkg.sv
rtl/pec_store.sv
rtl/pec_cross.sv
rtl/pec_ctrl.sv
rtl/polygon_ear_clip_triangulator.sv
rtl/pec_checker.sv
tb/polygon_ear_clip_triangulator_tb.sv
